@@ rtl/core/rmq_pkg.sv @@
package rmq_pkg;

   // slot of the large (0.25*s) component in the result
   typedef enum logic [1:0] {
      POS_0,
      POS_1,
      POS_2,
      POS_3
   } rmq_pos_type;

endpackage

@@ rtl/core/rmq_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// root_out = floor(sqrt(x_in)), RW stages.
module rmq_sqrt
   import rmq_pkg::*;
#(
   parameter int IW = 32
) (
   input  logic                clock,
   input  logic                enable,
   input  logic [IW-1:0]       x_in,
   output logic [IW/2-1:0]     root_out
);

   localparam int RW = IW / 2;

   logic [RW:0]   rem_ff  [RW];
   logic [RW-1:0] root_ff [RW];
   logic [IW-1:0] x_ff    [RW];
   logic [RW:0]   rem_in  [RW];
   logic [RW-1:0] root_in [RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [RW:0]   rem_prev;
      logic [RW-1:0] root_prev;
      logic [IW-1:0] x_prev;
      logic [RW+2:0] rem_sh;
      logic [RW+2:0] trial;
      logic [RW+2:0] diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign x_prev    = x_in;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign x_prev    = x_ff[k-1];
      end

      // bring down the next two radicand bits and try the next root bit
      assign rem_sh     = {rem_prev, x_prev[IW-1-2*k -: 2]};
      assign trial      = {1'b0, root_prev, 2'b01};
      assign ge         = rem_sh >= trial;
      assign diff       = rem_sh - trial;
      assign rem_in[k]  = ge ? diff[RW:0] : rem_sh[RW:0];
      assign root_in[k] = {root_prev[RW-2:0], ge};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            x_ff[k]    <= x_prev;
         end
      end
   end

   assign root_out = root_ff[RW-1];

endmodule

@@ rtl/core/rmq_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// quo_out = num_in / den_in (unsigned), NW stages.
// A zero divisor gives a meaningless quotient; the caller handles it.
module rmq_div
   import rmq_pkg::*;
#(
   parameter int NW = 31,
   parameter int DW = 17
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   output logic [NW-1:0] quo_out
);

   logic [DW-1:0] rem_ff [NW];
   logic [NW-1:0] quo_ff [NW];
   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] den_ff [NW];
   logic [DW-1:0] rem_in [NW];
   logic [NW-1:0] quo_in [NW];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [DW-1:0] rem_prev;
      logic [NW-1:0] quo_prev;
      logic [NW-1:0] num_prev;
      logic [DW-1:0] den_prev;
      logic [DW:0]   rem_sh;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign quo_prev = '0;
         assign num_prev = num_in;
         assign den_prev = den_in;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign quo_prev = quo_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
      end

      // shift in the next dividend bit, subtract if it fits
      assign rem_sh    = {rem_prev, num_prev[NW-1-k]};
      assign ge        = rem_sh >= {1'b0, den_prev};
      assign diff      = rem_sh - {1'b0, den_prev};
      assign rem_in[k] = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      assign quo_in[k] = {quo_prev[NW-2:0], ge};

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
            num_ff[k] <= num_prev;
            den_ff[k] <= den_prev;
         end
      end
   end

   assign quo_out = quo_ff[NW-1];

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_unit.sv @@
// Pipeline: a request is registered in stage A, then passes the square root, where RW is the
// root width (one square-root stage per root bit), and the dividers, NW = DATA_WIDTH + 1 +
// FRAC_BITS deep (one stage per quotient bit), and is then held in the output register.
// Throughput: one request per cycle; the whole pipeline holds while a result is stalled.
// Reset: synchronous, clears all valid bits; data registers are not reset.
module rotation_matrix_to_quaternion_unit
   import rmq_pkg::*;
#(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_elem_00,
   input  logic signed [DATA_WIDTH-1:0] req_elem_01,
   input  logic signed [DATA_WIDTH-1:0] req_elem_02,
   input  logic signed [DATA_WIDTH-1:0] req_elem_10,
   input  logic signed [DATA_WIDTH-1:0] req_elem_11,
   input  logic signed [DATA_WIDTH-1:0] req_elem_12,
   input  logic signed [DATA_WIDTH-1:0] req_elem_20,
   input  logic signed [DATA_WIDTH-1:0] req_elem_21,
   input  logic signed [DATA_WIDTH-1:0] req_elem_22,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_part0,
   output logic signed [DATA_WIDTH-1:0] rsp_part1,
   output logic signed [DATA_WIDTH-1:0] rsp_part2,
   output logic signed [DATA_WIDTH-1:0] rsp_part3,
   output logic                         rsp_saturated
);

   localparam int W    = DATA_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int TW   = ((W > F + 1) ? W : F + 1) + 3;
   localparam int XW   = TW - 1 + F;
   localparam int IW   = XW + (XW % 2);
   localparam int RW   = IW / 2;
   localparam int NUMW = W + 1;
   localparam int NW   = W + 1 + F;
   localparam int DW   = RW + 1;
   localparam int LW   = RW + W;
   localparam int LAT  = 1 + RW + NW;

   localparam logic signed [TW-1:0] ONE_T = {{(TW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
   localparam logic [W-1:0]  VMAX      = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]  VMIN      = {1'b1, {(W-1){1'b0}}};
   localparam logic [NW-1:0] Q_POS_LIM = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [NW-1:0] Q_NEG_LIM = {{(NW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic [LW-1:0] L_POS_LIM = {{(LW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [LW-1:0] L_NEG_LIM = {{(LW-W){1'b0}}, 1'b1, {(W-1){1'b0}}};
   localparam logic          ONE_SAT   = (F >= W - 1);
   localparam logic [W-1:0]  ONE_OUT   = (F >= W - 1) ? VMAX : (W'(1) << F);

   typedef struct packed {
      logic                   tr_one;
      logic                   tr_pos;
      logic                   flip;
      rmq_pos_type            pos;
      logic signed [NUMW-1:0] na;
      logic signed [NUMW-1:0] nb;
      logic signed [NUMW-1:0] nc;
   } side_type;

   logic           adv;
   logic           rsp_valid_ff;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;

   // whole pipeline moves unless a finished result is held
   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage A: branch select, trace, numerators
   logic signed [TW-1:0]   e00, e11, e22;
   logic signed [TW-1:0]   tr;
   logic signed [NUMW-1:0] sum_diag;
   logic [XW-1:0]          tr_sh;
   side_type               side_a_in;
   side_type               side_a_ff;
   logic [IW-1:0]          x_a_in;
   logic [IW-1:0]          x_a_ff;

   always_comb begin
      e00      = TW'(req_elem_00);
      e11      = TW'(req_elem_11);
      e22      = TW'(req_elem_22);
      sum_diag = NUMW'(req_elem_00) + NUMW'(req_elem_11);
      side_a_in = '0;
      if (req_elem_22 < 0) begin
         if (req_elem_00 > req_elem_11) begin
            tr             = ONE_T + e00 - e11 - e22;
            side_a_in.flip = req_elem_12 < req_elem_21;
            side_a_in.na   = NUMW'(req_elem_12) - NUMW'(req_elem_21);
            side_a_in.nb   = NUMW'(req_elem_01) + NUMW'(req_elem_10);
            side_a_in.nc   = NUMW'(req_elem_20) + NUMW'(req_elem_02);
            side_a_in.pos  = POS_1;
         end else begin
            tr             = ONE_T - e00 - e11 + e22;
            side_a_in.flip = req_elem_20 < req_elem_02;
            side_a_in.na   = NUMW'(req_elem_20) - NUMW'(req_elem_02);
            side_a_in.nb   = NUMW'(req_elem_01) + NUMW'(req_elem_10);
            side_a_in.nc   = NUMW'(req_elem_12) + NUMW'(req_elem_21);
            side_a_in.pos  = POS_2;
         end
      end else begin
         if (sum_diag < 0) begin
            tr             = ONE_T - e00 + e11 + e22;
            side_a_in.flip = req_elem_01 < req_elem_10;
            side_a_in.na   = NUMW'(req_elem_01) - NUMW'(req_elem_10);
            side_a_in.nb   = NUMW'(req_elem_20) + NUMW'(req_elem_02);
            side_a_in.nc   = NUMW'(req_elem_12) + NUMW'(req_elem_21);
            side_a_in.pos  = POS_3;
         end else begin
            tr             = ONE_T + e00 + e11 + e22;
            side_a_in.flip = 1'b0;
            side_a_in.na   = NUMW'(req_elem_12) - NUMW'(req_elem_21);
            side_a_in.nb   = NUMW'(req_elem_20) - NUMW'(req_elem_02);
            side_a_in.nc   = NUMW'(req_elem_01) - NUMW'(req_elem_10);
            side_a_in.pos  = POS_0;
         end
      end
      side_a_in.tr_one = tr == ONE_T;
      side_a_in.tr_pos = tr > 0;
      tr_sh  = {tr[TW-2:0], {F{1'b0}}};
      x_a_in = side_a_in.tr_pos ? IW'(tr_sh) : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_a_ff <= side_a_in;
         x_a_ff    <= x_a_in;
      end
   end

   // square root, sideband delayed alongside
   logic [RW-1:0] root;
   side_type      side_q_ff [RW];

   rmq_sqrt #(.IW(IW)) u_sqrt (
      .clock    (clock),
      .enable   (adv),
      .x_in     (x_a_ff),
      .root_out (root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < RW; i++) begin
            if (i == 0) side_q_ff[i] <= side_a_ff;
            else        side_q_ff[i] <= side_q_ff[i-1];
         end
      end
   end

   // three dividers on magnitudes, divisor S = 2*root
   side_type               side_q;
   logic [NUMW-1:0]        mag_a, mag_b, mag_c;
   logic [DW-1:0]          den;
   logic [NW-1:0]          quo_a, quo_b, quo_c;
   side_type               side_d_ff [NW];
   logic [RW-1:0]          root_d_ff [NW];

   assign side_q = side_q_ff[RW-1];
   assign mag_a  = side_q.na[NUMW-1] ? NUMW'(-side_q.na) : NUMW'(side_q.na);
   assign mag_b  = side_q.nb[NUMW-1] ? NUMW'(-side_q.nb) : NUMW'(side_q.nb);
   assign mag_c  = side_q.nc[NUMW-1] ? NUMW'(-side_q.nc) : NUMW'(side_q.nc);
   assign den    = {root, 1'b0};

   rmq_div #(.NW(NW), .DW(DW)) u_div_a (
      .clock   (clock),
      .enable  (adv),
      .num_in  ({mag_a, {F{1'b0}}}),
      .den_in  (den),
      .quo_out (quo_a)
   );

   rmq_div #(.NW(NW), .DW(DW)) u_div_b (
      .clock   (clock),
      .enable  (adv),
      .num_in  ({mag_b, {F{1'b0}}}),
      .den_in  (den),
      .quo_out (quo_b)
   );

   rmq_div #(.NW(NW), .DW(DW)) u_div_c (
      .clock   (clock),
      .enable  (adv),
      .num_in  ({mag_c, {F{1'b0}}}),
      .den_in  (den),
      .quo_out (quo_c)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < NW; i++) begin
            if (i == 0) begin
               side_d_ff[i] <= side_q;
               root_d_ff[i] <= root;
            end else begin
               side_d_ff[i] <= side_d_ff[i-1];
               root_d_ff[i] <= root_d_ff[i-1];
            end
         end
      end
   end

   // sign, saturation, zero divisor; returns {flag, value}
   function automatic logic [W:0] quo_fix(input logic [NW-1:0] q,
                                          input logic signed [NUMW-1:0] num,
                                          input logic flip,
                                          input logic zero);
      logic          neg;
      logic [NW-1:0] nq;
      logic [W-1:0]  v;
      logic          f;
      f   = 1'b0;
      neg = num[NUMW-1] ^ flip;
      nq  = ~q + NW'(1);
      if (zero) begin
         f = 1'b1;
         if (num[NUMW-1])  v = VMIN;
         else if (num != 0) v = VMAX;
         else               v = '0;
      end else if (!neg) begin
         if (q > Q_POS_LIM) begin
            v = VMAX;
            f = 1'b1;
         end else begin
            v = q[W-1:0];
         end
      end else begin
         if (q > Q_NEG_LIM) begin
            v = VMIN;
            f = 1'b1;
         end else begin
            v = nq[W-1:0];
         end
      end
      return {f, v};
   endfunction

   // output stage: fix-up, identity case, placement
   side_type      side_d;
   logic [W:0]    fa, fb, fc;
   logic [RW-1:0] lm;
   logic [LW-1:0] lme, lneg;
   logic [W-1:0]  big_part;
   logic          flag;
   logic [W-1:0]  part0_in, part1_in, part2_in, part3_in;
   logic [W-1:0]  part0_ff, part1_ff, part2_ff, part3_ff;
   logic          sat_ff;

   always_comb begin
      side_d = side_d_ff[NW-1];
      fa     = quo_fix(quo_a, side_d.na, side_d.flip, !side_d.tr_pos);
      fb     = quo_fix(quo_b, side_d.nb, side_d.flip, !side_d.tr_pos);
      fc     = quo_fix(quo_c, side_d.nc, side_d.flip, !side_d.tr_pos);
      flag   = fa[W] | fb[W] | fc[W];
      lm     = root_d_ff[NW-1] >> 1;
      lme    = LW'(lm);
      lneg   = ~lme + LW'(1);
      if (side_d.flip) begin
         if (lme > L_NEG_LIM) begin
            big_part = VMIN;
            flag     = 1'b1;
         end else begin
            big_part = lneg[W-1:0];
         end
      end else begin
         if (lme > L_POS_LIM) begin
            big_part = VMAX;
            flag     = 1'b1;
         end else begin
            big_part = lme[W-1:0];
         end
      end
      // trace term of exactly one with the other three parts zero: force the large component to one
      if (side_d.tr_one && fa[W-1:0] == '0 && fb[W-1:0] == '0 && fc[W-1:0] == '0) begin
         big_part = ONE_OUT;
         flag     = flag | ONE_SAT;
      end
      part0_in = fa[W-1:0];
      part1_in = fb[W-1:0];
      part2_in = fc[W-1:0];
      part3_in = big_part;
      case (side_d.pos)
         POS_0: begin
            part0_in = big_part;
            part1_in = fa[W-1:0];
            part2_in = fb[W-1:0];
            part3_in = fc[W-1:0];
         end
         POS_1: begin
            part0_in = fa[W-1:0];
            part1_in = big_part;
            part2_in = fb[W-1:0];
            part3_in = fc[W-1:0];
         end
         POS_2: begin
            part0_in = fa[W-1:0];
            part1_in = fb[W-1:0];
            part2_in = big_part;
            part3_in = fc[W-1:0];
         end
         default: begin
            part3_in = big_part;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         part0_ff <= part0_in;
         part1_ff <= part1_in;
         part2_ff <= part2_in;
         part3_ff <= part3_in;
         sat_ff   <= flag;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_part0     = part0_ff;
   assign rsp_part1     = part1_ff;
   assign rsp_part2     = part2_ff;
   assign rsp_part3     = part3_ff;
   assign rsp_saturated = sat_ff;

endmodule
